@@ hw/rtl/rci_pkg.sv @@
// Shared types, register indexes, constants and fixed-point helpers for the
// ray/cone intersection block. No dependencies.
`default_nettype none

package rci_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_Z      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_RADIUS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CONE_HEIGHT = 3'd4;

   localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
   localparam logic signed [31:0] EPS_Q   = 32'sd66;
   localparam logic signed [31:0] MISS_T  = 32'shFFFF_0000;
   localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;

   // square root: radicand is delta shifted up by 16, root is 24 bits
   localparam int SQ_ROOT_W = 24;
   localparam int SQRT_LAT  = SQ_ROOT_W;
   // root divider: one operand stage, one stage per quotient bit, one output stage
   localparam int DIV_Q_W   = 32;
   localparam int DIV_IN_W  = 34;
   localparam int DIV_LAT   = DIV_Q_W + 2;
   // front: 6 stages; numerator stage: 1; back: height product and range test
   localparam int FRONT_LAT = 6;
   localparam int PIPE_LAT  = FRONT_LAT + SQRT_LAT + 1 + DIV_LAT + 2;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
   } rci_ray_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] distance;
   } rci_result_type;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sd2147483647)
         r = Q_MAX;
      else if (v < -36'sd2147483648)
         r = Q_MIN;
      else
         r = v[31:0];
      return r;
   endfunction

   // Q16.16 product, floor shift by 16, saturate
   function automatic logic signed [31:0] qmul(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
      logic signed [63:0] p;
      logic signed [31:0] r;
      p = x * y;
      if (!p[63] && (|p[62:47]))
         r = Q_MAX;
      else if (p[63] && !(&p[62:47]))
         r = Q_MIN;
      else
         r = p[47:16];
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rci_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
// Depends on rci_pkg.
`default_nettype none

module rci_sqrt import rci_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire logic [2*SQ_ROOT_W-1:0]   radicand,
   output logic                          out_valid,
   output logic [SQ_ROOT_W-1:0]          root
);

   localparam int N  = SQ_ROOT_W;
   localparam int RW = 2*SQ_ROOT_W + 2;

   logic [RW-1:0] rem_ff  [N];
   logic [N-1:0]  root_ff [N];
   logic          vld_ff  [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [RW-1:0] rem_prev;
      logic [RW-1:0] trial;
      logic [N-1:0]  root_prev;
      logic          vld_prev;

      if (k == 0) begin : g_first
         assign rem_prev  = RW'(radicand);
         assign root_prev = '0;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      // (2q + 2^j) * 2^j for bit j = N-1-k
      assign trial = (RW'(root_prev) << (N-k)) + (RW'(1) << (2*(N-1-k)));

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (rem_prev >= trial) begin
            rem_ff[k]  <= rem_prev - trial;
            root_ff[k] <= root_prev | (N'(1) << (N-1-k));
         end else begin
            rem_ff[k]  <= rem_prev;
            root_ff[k] <= root_prev;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign root      = root_ff[N-1];

endmodule

`default_nettype wire

@@ hw/rtl/rci_div.sv @@
// Pipelined signed Q16.16 divide (num * 2^16) / den, truncating, saturated.
// Depends on rci_pkg.
`default_nettype none

module rci_div import rci_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic signed [DIV_IN_W-1:0] num,
   input  wire logic signed [DIV_IN_W-1:0] den,
   output logic                            out_valid,
   output logic signed [31:0]              quot
);

   localparam int N  = DIV_Q_W;
   localparam int RW = DIV_IN_W + N;

   logic [DIV_IN_W-1:0] nmag;
   logic [DIV_IN_W-1:0] dmag;

   logic [RW-1:0]       a_rem_ff;
   logic [DIV_IN_W-1:0] a_dmag_ff;
   logic                a_neg_ff;
   logic                a_ovf_ff;
   logic                a_vld_ff;

   logic [RW-1:0]       rem_ff  [N];
   logic [N-1:0]        q_ff    [N];
   logic [DIV_IN_W-1:0] dmag_ff [N];
   logic                neg_ff  [N];
   logic                ovf_ff  [N];
   logic                vld_ff  [N];

   logic signed [31:0]  quot_ff;
   logic                out_vld_ff;

   assign nmag = num[DIV_IN_W-1] ? DIV_IN_W'(-num) : DIV_IN_W'(num);
   assign dmag = den[DIV_IN_W-1] ? DIV_IN_W'(-den) : DIV_IN_W'(den);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_valid;
      end
   end

   // quotient fits in N bits only when |num| << 16 < |den| << N
   always_ff @(posedge clock) begin
      a_rem_ff  <= RW'({nmag, 16'b0});
      a_dmag_ff <= dmag;
      a_neg_ff  <= num[DIV_IN_W-1] ^ den[DIV_IN_W-1];
      a_ovf_ff  <= RW'({nmag, 16'b0}) >= (RW'(dmag) << N);
   end

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [RW-1:0]       rem_prev;
      logic [RW-1:0]       trial;
      logic [N-1:0]        q_prev;
      logic [DIV_IN_W-1:0] d_prev;
      logic                neg_prev;
      logic                ovf_prev;
      logic                vld_prev;

      if (k == 0) begin : g_first
         assign rem_prev = a_rem_ff;
         assign q_prev   = '0;
         assign d_prev   = a_dmag_ff;
         assign neg_prev = a_neg_ff;
         assign ovf_prev = a_ovf_ff;
         assign vld_prev = a_vld_ff;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign q_prev   = q_ff[k-1];
         assign d_prev   = dmag_ff[k-1];
         assign neg_prev = neg_ff[k-1];
         assign ovf_prev = ovf_ff[k-1];
         assign vld_prev = vld_ff[k-1];
      end

      assign trial = RW'(d_prev) << (N-1-k);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         dmag_ff[k] <= d_prev;
         neg_ff[k]  <= neg_prev;
         ovf_ff[k]  <= ovf_prev;
         if (rem_prev >= trial) begin
            rem_ff[k] <= rem_prev - trial;
            q_ff[k]   <= q_prev | (N'(1) << (N-1-k));
         end else begin
            rem_ff[k] <= rem_prev;
            q_ff[k]   <= q_prev;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vld_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (ovf_ff[N-1]) begin
         quot_ff <= neg_ff[N-1] ? Q_MIN : Q_MAX;
      end else if (neg_ff[N-1]) begin
         quot_ff <= (q_ff[N-1][N-1] && (|q_ff[N-1][N-2:0])) ? Q_MIN
                                                              : 32'(-q_ff[N-1]);
      end else begin
         quot_ff <= q_ff[N-1][N-1] ? Q_MAX : $signed(q_ff[N-1]);
      end
   end

   assign out_valid = out_vld_ff;
   assign quot      = quot_ff;

endmodule

`default_nettype wire

@@ hw/rtl/ray_cone_intersect_top.sv @@
// Ray against upright finite cone, signed Q16.16, fully pipelined.
// One item per cycle while busy is low.
// busy rises after a write to base_radius or cone_height and stays high while the
// cone slope is recomputed by a bit-serial divider; the item pipe itself never stalls.
// Reset (synchronous): registers to base 0, radius 1.0, height 1.0, pipe emptied.
// Depends on rci_pkg, rci_sqrt, rci_div.
`default_nettype none

module ray_cone_intersect_top import rci_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // item in
   input  wire logic                  start,
   output logic                       busy,
   input  wire rci_ray_type           req_ray,
   // result out, one-cycle strobe
   output logic                       rsp_valid,
   output rci_result_type             rsp_result,
   // register writes
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int RNUM_W = 47;
   localparam int RCNT_W = $clog2(RNUM_W);

   typedef enum logic [1:0] {RT_IDLE, RT_DIVIDE, RT_SQUARE} rt_state_type;

   // context riding alongside the square root
   typedef struct packed {
      logic               vld;
      logic               ok;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] oy;
      logic signed [31:0] dy;
   } sq_ctx_type;

   // context riding alongside the root dividers
   typedef struct packed {
      logic               vld;
      logic               ok;
      logic signed [31:0] oy;
      logic signed [31:0] dy;
   } dv_ctx_type;

   // ---------------------------------------------------------------- registers
   logic signed [31:0] base_x_ff;
   logic signed [31:0] base_y_ff;
   logic signed [31:0] base_z_ff;
   logic [30:0]        base_radius_ff;
   logic [30:0]        cone_height_ff;
   logic               slope_write;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff      <= '0;
         base_y_ff      <= '0;
         base_z_ff      <= '0;
         base_radius_ff <= 31'(Q_ONE);
         cone_height_ff <= 31'(Q_ONE);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_X:      base_x_ff      <= $signed(csr_wdata);
            CSR_BASE_Y:      base_y_ff      <= $signed(csr_wdata);
            CSR_BASE_Z:      base_z_ff      <= $signed(csr_wdata);
            CSR_BASE_RADIUS: base_radius_ff <= csr_wdata[30:0];
            CSR_CONE_HEIGHT: cone_height_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   assign slope_write = csr_we &&
                        (csr_index == CSR_BASE_RADIUS || csr_index == CSR_CONE_HEIGHT);

   // ---------------------------------------------------------------- slope unit
   // ratio = (radius << 16) / height, one quotient bit per cycle; then tan2 = ratio^2.
   // Height zero yields an all-ones quotient, which saturates as required.
   rt_state_type       rstate_ff;
   logic               recalc_ff;
   logic [RNUM_W-1:0]  rnum_ff;
   logic [31:0]        rrem_ff;
   logic [RNUM_W-1:0]  rquo_ff;
   logic [RCNT_W-1:0]  rcnt_ff;
   logic [30:0]        ratio_ff;
   logic signed [31:0] tan2_ff;

   logic [32:0]        rtrial;
   logic               rge;
   logic [31:0]        rrem_in;
   logic [RNUM_W-1:0]  rquo_in;

   assign rtrial  = {rrem_ff, rnum_ff[RNUM_W-1]};
   assign rge     = rtrial >= {2'b0, cone_height_ff};
   assign rrem_in = rge ? 32'(rtrial - {2'b0, cone_height_ff}) : rtrial[31:0];
   assign rquo_in = {rquo_ff[RNUM_W-2:0], rge};

   always_ff @(posedge clock) begin
      if (reset) begin
         rstate_ff <= RT_IDLE;
         recalc_ff <= 1'b0;
         ratio_ff  <= 31'(Q_ONE);
         tan2_ff   <= Q_ONE;
      end else begin
         recalc_ff <= slope_write || (recalc_ff && rstate_ff != RT_IDLE);
         unique case (rstate_ff)
            RT_IDLE: begin
               if (recalc_ff) begin
                  rnum_ff   <= {base_radius_ff, 16'b0};
                  rrem_ff   <= '0;
                  rquo_ff   <= '0;
                  rcnt_ff   <= RCNT_W'(RNUM_W - 1);
                  rstate_ff <= RT_DIVIDE;
               end
            end
            RT_DIVIDE: begin
               rnum_ff <= rnum_ff << 1;
               rrem_ff <= rrem_in;
               rquo_ff <= rquo_in;
               rcnt_ff <= rcnt_ff - 1'b1;
               if (rcnt_ff == '0) begin
                  ratio_ff  <= (|rquo_in[RNUM_W-1:31]) ? '1 : rquo_in[30:0];
                  rstate_ff <= RT_SQUARE;
               end
            end
            RT_SQUARE: begin
               tan2_ff   <= qmul($signed({1'b0, ratio_ff}), $signed({1'b0, ratio_ff}));
               rstate_ff <= RT_IDLE;
            end
            default: rstate_ff <= RT_IDLE;
         endcase
      end
   end

   assign busy = (rstate_ff != RT_IDLE) || recalc_ff;

   logic accept;
   assign accept = start && !busy;

   // ---------------------------------------------------------------- stage 1
   // offsets from the base center, height left to the apex
   logic               v1_ff;
   logic signed [31:0] s1_vx_ff, s1_vz_ff, s1_yc_ff;
   logic signed [31:0] s1_dx_ff, s1_dy_ff, s1_dz_ff, s1_oy_ff;

   always_ff @(posedge clock) begin
      s1_vx_ff <= sat32(36'(req_ray.origin_x) - 36'(base_x_ff));
      s1_vz_ff <= sat32(36'(req_ray.origin_z) - 36'(base_z_ff));
      s1_yc_ff <= sat32(36'($signed({1'b0, cone_height_ff})) - 36'(req_ray.origin_y)
                        + 36'(base_y_ff));
      s1_dx_ff <= req_ray.dir_x;
      s1_dy_ff <= req_ray.dir_y;
      s1_dz_ff <= req_ray.dir_z;
      s1_oy_ff <= req_ray.origin_y;
   end

   // ---------------------------------------------------------------- stage 2
   // first products
   logic               v2_ff;
   logic signed [31:0] p_dxdx_ff, p_dzdz_ff, p_dydy_ff, p_vxdx_ff, p_vzdz_ff;
   logic signed [31:0] p_vxvx_ff, p_vzvz_ff, p_ycyc_ff, p_tyc_ff;
   logic signed [31:0] s2_dy_ff, s2_oy_ff;

   always_ff @(posedge clock) begin
      p_dxdx_ff <= qmul(s1_dx_ff, s1_dx_ff);
      p_dzdz_ff <= qmul(s1_dz_ff, s1_dz_ff);
      p_dydy_ff <= qmul(s1_dy_ff, s1_dy_ff);
      p_vxdx_ff <= qmul(s1_vx_ff, s1_dx_ff);
      p_vzdz_ff <= qmul(s1_vz_ff, s1_dz_ff);
      p_vxvx_ff <= qmul(s1_vx_ff, s1_vx_ff);
      p_vzvz_ff <= qmul(s1_vz_ff, s1_vz_ff);
      p_ycyc_ff <= qmul(s1_yc_ff, s1_yc_ff);
      p_tyc_ff  <= qmul(tan2_ff, s1_yc_ff);
      s2_dy_ff  <= s1_dy_ff;
      s2_oy_ff  <= s1_oy_ff;
   end

   // ---------------------------------------------------------------- stage 3
   // slope-scaled products and partial sums
   logic               v3_ff;
   logic signed [31:0] q_tdd_ff, q_tyd_ff, q_tyy_ff;
   logic signed [35:0] sum_a_ff, sum_b_ff, sum_c_ff;
   logic signed [31:0] s3_dy_ff, s3_oy_ff;

   always_ff @(posedge clock) begin
      q_tdd_ff <= qmul(tan2_ff, p_dydy_ff);
      q_tyd_ff <= qmul(p_tyc_ff, s2_dy_ff);
      q_tyy_ff <= qmul(tan2_ff, p_ycyc_ff);
      sum_a_ff <= 36'(p_dxdx_ff) + 36'(p_dzdz_ff);
      sum_b_ff <= 36'(p_vxdx_ff) + 36'(p_vzdz_ff);
      sum_c_ff <= 36'(p_vxvx_ff) + 36'(p_vzvz_ff);
      s3_dy_ff <= s2_dy_ff;
      s3_oy_ff <= s2_oy_ff;
   end

   // ---------------------------------------------------------------- stage 4
   // quadratic coefficients
   logic               v4_ff;
   logic signed [31:0] a4_ff, b4_ff, c4_ff;
   logic signed [31:0] s4_dy_ff, s4_oy_ff;

   always_ff @(posedge clock) begin
      a4_ff    <= sat32(sum_a_ff - 36'(q_tdd_ff));
      b4_ff    <= sat32((sum_b_ff + 36'(q_tyd_ff)) <<< 1);
      c4_ff    <= sat32(sum_c_ff - 36'(q_tyy_ff));
      s4_dy_ff <= s3_dy_ff;
      s4_oy_ff <= s3_oy_ff;
   end

   // ---------------------------------------------------------------- stage 5
   logic               v5_ff;
   logic signed [31:0] bb5_ff, ac5_ff, a5_ff, b5_ff, s5_dy_ff, s5_oy_ff;

   always_ff @(posedge clock) begin
      bb5_ff   <= qmul(b4_ff, b4_ff);
      ac5_ff   <= qmul(a4_ff, c4_ff);
      a5_ff    <= a4_ff;
      b5_ff    <= b4_ff;
      s5_dy_ff <= s4_dy_ff;
      s5_oy_ff <= s4_oy_ff;
   end

   // ---------------------------------------------------------------- stage 6
   // discriminant and the hit-possible flag
   logic signed [31:0] delta_in;
   logic signed [31:0] delta6_ff;
   sq_ctx_type         ctx6_ff;

   assign delta_in = sat32(36'(bb5_ff) - (36'(ac5_ff) <<< 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx6_ff.vld <= 1'b0;
      end else begin
         ctx6_ff.vld <= v5_ff;
      end
      delta6_ff  <= delta_in;
      ctx6_ff.ok <= (delta_in >= EPS_Q) && (a5_ff != '0);
      ctx6_ff.a  <= a5_ff;
      ctx6_ff.b  <= b5_ff;
      ctx6_ff.oy <= s5_oy_ff;
      ctx6_ff.dy <= s5_dy_ff;
   end

   // front valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // ---------------------------------------------------------------- square root
   logic                 sq_vld;
   logic [SQ_ROOT_W-1:0] sq_root;
   sq_ctx_type           sq_dly_ff [SQRT_LAT];

   rci_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ctx6_ff.vld),
      .radicand  ({delta6_ff, 16'b0}),
      .out_valid (sq_vld),
      .root      (sq_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SQRT_LAT; i++) sq_dly_ff[i].vld <= 1'b0;
      end else begin
         sq_dly_ff[0] <= ctx6_ff;
         for (int i = 1; i < SQRT_LAT; i++) sq_dly_ff[i] <= sq_dly_ff[i-1];
      end
   end

   // ---------------------------------------------------------------- numerators
   logic signed [DIV_IN_W-1:0] num1_ff, num2_ff, den_ff;
   dv_ctx_type                 ctx31_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx31_ff.vld <= 1'b0;
      end else begin
         ctx31_ff.vld <= sq_vld;
      end
      num1_ff     <= -DIV_IN_W'(sq_dly_ff[SQRT_LAT-1].b)
                     - $signed(DIV_IN_W'(sq_root));
      num2_ff     <= -DIV_IN_W'(sq_dly_ff[SQRT_LAT-1].b)
                     + $signed(DIV_IN_W'(sq_root));
      den_ff      <= DIV_IN_W'(sq_dly_ff[SQRT_LAT-1].a) <<< 1;
      ctx31_ff.ok <= sq_dly_ff[SQRT_LAT-1].ok;
      ctx31_ff.oy <= sq_dly_ff[SQRT_LAT-1].oy;
      ctx31_ff.dy <= sq_dly_ff[SQRT_LAT-1].dy;
   end

   // ---------------------------------------------------------------- root dividers
   // near root and far root side by side
   logic               dv1_vld, dv2_vld;
   logic signed [31:0] t1, t2;
   dv_ctx_type         dv_dly_ff [DIV_LAT];

   rci_div u_div_near (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ctx31_ff.vld),
      .num       (num1_ff),
      .den       (den_ff),
      .out_valid (dv1_vld),
      .quot      (t1)
   );

   rci_div u_div_far (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ctx31_ff.vld),
      .num       (num2_ff),
      .den       (den_ff),
      .out_valid (dv2_vld),
      .quot      (t2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) dv_dly_ff[i].vld <= 1'b0;
      end else begin
         dv_dly_ff[0] <= ctx31_ff;
         for (int i = 1; i < DIV_LAT; i++) dv_dly_ff[i] <= dv_dly_ff[i-1];
      end
   end

   // ---------------------------------------------------------------- hit heights
   logic               v66_ff;
   logic               ok66_ff;
   logic signed [31:0] m1_ff, m2_ff, t1_66_ff, t2_66_ff, oy66_ff;

   always_ff @(posedge clock) begin
      m1_ff    <= qmul(dv_dly_ff[DIV_LAT-1].dy, t1);
      m2_ff    <= qmul(dv_dly_ff[DIV_LAT-1].dy, t2);
      t1_66_ff <= t1;
      t2_66_ff <= t2;
      oy66_ff  <= dv_dly_ff[DIV_LAT-1].oy;
      ok66_ff  <= dv_dly_ff[DIV_LAT-1].ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v66_ff <= 1'b0;
      end else begin
         v66_ff <= dv_dly_ff[DIV_LAT-1].vld && dv1_vld && dv2_vld;
      end
   end

   // ---------------------------------------------------------------- range test, result
   // near root wins when its height lies on the cone, else the far root
   logic signed [33:0] y1, y2, y_lo, y_hi;
   logic               in1, in2;
   logic               rsp_valid_ff;
   rci_result_type     rsp_result_ff;

   assign y1   = 34'(oy66_ff) + 34'(m1_ff);
   assign y2   = 34'(oy66_ff) + 34'(m2_ff);
   assign y_lo = 34'(base_y_ff);
   assign y_hi = 34'(base_y_ff) + 34'($signed({1'b0, cone_height_ff}));
   assign in1  = (y1 >= y_lo) && (y1 <= y_hi);
   assign in2  = (y2 >= y_lo) && (y2 <= y_hi);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= v66_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_ff.hit <= ok66_ff && (in1 || in2);
      if (ok66_ff && in1)
         rsp_result_ff.distance <= t1_66_ff;
      else if (ok66_ff && in2)
         rsp_result_ff.distance <= t2_66_ff;
      else
         rsp_result_ff.distance <= MISS_T;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

`ifndef NO_ASSERTIONS
   // every accepted item comes out after the fixed pipe latency
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PIPE_LAT rsp_valid)
      else $error("item lost in pipe");

   // a miss always carries the miss distance
   a_miss_dist : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result.hit |-> rsp_result.distance == MISS_T)
      else $error("miss with distance other than -1.0");

   // a slope register write holds off items until the slope is recomputed
   a_slope_busy : assert property (@(posedge clock) disable iff (reset)
      slope_write |=> busy)
      else $error("busy not raised after slope write");

   // root dividers and context line stay aligned
   a_div_align : assert property (@(posedge clock) disable iff (reset)
      dv1_vld == dv_dly_ff[DIV_LAT-1].vld && dv2_vld == dv1_vld)
      else $error("divider output misaligned with context");
`endif

endmodule

`default_nettype wire
